>>> hdl/nwss_pkg.sv
// Shared types, codes and elaboration-time table arithmetic for the neuron block.
`default_nettype none

package nwss_pkg;

    // Default sizes handed to the top-level parameters.
    localparam int MAX_INPUTS_DEF = 64;
    localparam int SIG_DEPTH_DEF  = 256;

    // Field widths fixed by the interface.
    localparam int INDEX_W = 6;
    localparam int VALUE_W = 16;
    localparam int MODE_W  = 2;
    localparam int CFG_W   = 2;
    localparam int ACC_W   = 48;
    localparam int PROD_W  = 32;
    localparam int SIG_W   = 13;

    // Request opcodes.
    localparam logic OP_WEIGHT = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_W-1:0] CFG_MODE  = 2'd0;
    localparam logic [CFG_W-1:0] CFG_SLOPE = 2'd1;
    localparam logic [CFG_W-1:0] CFG_BIAS  = 2'd2;

    // Transfer function codes; any other code behaves as linear.
    localparam logic [MODE_W-1:0] MODE_UNARY  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BINARY = 2'd1;

    // Reset value of the slope register, and the constant one in Q.12.
    localparam logic [VALUE_W-1:0] SLOPE_RST = 16'd4096;
    localparam logic [VALUE_W-1:0] Q12_ONE   = 16'd4096;

    typedef struct packed {
        logic                      op;
        logic [INDEX_W-1:0]        index;
        logic signed [VALUE_W-1:0] value;
        logic                      last;
    } t_in;

    typedef struct packed {
        logic signed [VALUE_W-1:0] activation;
        logic                      saturated;
    } t_out;

    // Shift-and-subtract division, used only while the sigmoid table is elaborated.
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[63:0], num[b]};
            if (r >= {1'b0, den}) begin
                r    = r - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // e^(-a/4096) in Q.30: Taylor series of e^(-a/32768), then squared three times.
    function automatic logic [63:0] exp_neg_q30(input logic [63:0] a);
        logic [63:0] s;
        logic [63:0] t;
        s = 64'd1 << 30;
        t = 64'd1 << 30;
        for (int k = 1; k <= 16; k++) begin
            t = udiv64((t * a) >> 15, 64'(k));
            if ((k & 1) == 1) begin
                s = s - t;
            end else begin
                s = s + t;
            end
        end
        for (int j = 0; j < 3; j++) begin
            s = ((s * s) + (64'd1 << 29)) >> 30;
        end
        return s;
    endfunction

    // Unary sigmoid in Q.12 at the midpoint of table cell idx.
    function automatic logic [SIG_W-1:0] sig_entry(input int idx, input int depth);
        logic [63:0] off;
        logic [63:0] a;
        logic [63:0] e;
        logic [63:0] d;
        logic [63:0] n;
        longint      m;
        off = udiv64(64'(2 * idx + 1) * 64'd65536, 64'(2 * depth));
        m   = longint'(off) - 64'sd32768;
        a   = (m < 0) ? 64'(-m) : 64'(m);
        e   = exp_neg_q30(a);
        d   = (64'd1 << 30) + e;
        n   = (m >= 0) ? (64'd1 << 42) : (e << 12);
        return SIG_W'(udiv64(n + (d >> 1), d));
    endfunction

endpackage

`default_nettype wire

>>> hdl/nwss_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none

module nwss_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

>>> hdl/nwss_act.sv
// Transfer stage: slope scaling, clamping, sigmoid table lookup and the result register.
`default_nettype none

module nwss_act #(
    parameter int SIGMOID_TABLE_DEPTH = nwss_pkg::SIG_DEPTH_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_start,
    input  wire logic [nwss_pkg::ACC_W-1:0]          i_acc,
    input  wire logic [nwss_pkg::MODE_W-1:0]         i_mode,
    input  wire logic signed [nwss_pkg::VALUE_W-1:0] i_slope,
    output logic                                     o_done,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output nwss_pkg::t_out                           o_out_res
);

    localparam int TW = $clog2(SIGMOID_TABLE_DEPTH);
    localparam int MW = 16 + $clog2(SIGMOID_TABLE_DEPTH + 1);

    // Constant sigmoid table, worked out at elaboration.
    logic [nwss_pkg::SIG_W-1:0] w_table [SIGMOID_TABLE_DEPTH];

    for (genvar g = 0; g < SIGMOID_TABLE_DEPTH; g++) begin : g_table
        localparam logic [nwss_pkg::SIG_W-1:0] ENTRY =
            nwss_pkg::sig_entry(g, SIGMOID_TABLE_DEPTH);
        assign w_table[g] = ENTRY;
    end

    logic                       r_f1_valid;
    logic signed [39:0]         r_p_hi;
    logic signed [40:0]         r_p_lo;
    logic                       r_f2_valid;
    logic [15:0]                r_f2_clamp;
    logic                       r_f2_sat;
    logic                       r_f3_valid;
    logic [TW-1:0]              r_f3_idx;
    logic [15:0]                r_f3_clamp;
    logic                       r_f3_sat;
    logic                       r_f4_valid;
    logic [nwss_pkg::SIG_W-1:0] r_f4_u;
    logic [15:0]                r_f4_clamp;
    logic                       r_f4_sat;
    logic                       r_out_valid;
    nwss_pkg::t_out             r_out_res;
    nwss_pkg::t_out             n_out_res;

    logic [40:0] w_rnd;
    logic [40:0] w_z;
    logic        w_sat_hi;
    logic        w_sat_lo;
    logic [15:0] w_ubias;
    logic [MW-1:0] w_tprod;
    logic        w_load;

    // The low half of the sum is rounded half up into the Q.12 result.
    assign w_rnd    = r_p_lo + 41'h000_0080_0000;
    assign w_z      = {r_p_hi[39], r_p_hi} + {{24{w_rnd[40]}}, w_rnd[40:24]};
    assign w_sat_hi = !w_z[40] && (w_z[39:15] != '0);
    assign w_sat_lo = w_z[40] && (w_z[39:15] != '1);

    assign w_ubias  = r_f2_clamp ^ 16'h8000;
    assign w_tprod  = MW'(w_ubias) * MW'(SIGMOID_TABLE_DEPTH);

    assign w_load   = r_f4_valid && (!r_out_valid || i_out_ready);

    always_comb begin
        n_out_res.saturated = 1'b0;
        unique case (i_mode)
            nwss_pkg::MODE_UNARY: begin
                n_out_res.activation = $signed({3'b000, r_f4_u});
            end
            nwss_pkg::MODE_BINARY: begin
                n_out_res.activation = $signed({2'b00, r_f4_u, 1'b0} - nwss_pkg::Q12_ONE);
            end
            default: begin
                n_out_res.activation = $signed(r_f4_clamp);
                n_out_res.saturated  = r_f4_sat;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid  <= 1'b0;
            r_f2_valid  <= 1'b0;
            r_f3_valid  <= 1'b0;
            r_f4_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_f1_valid <= i_start;
            r_f2_valid <= r_f1_valid;
            r_f3_valid <= r_f2_valid;
            if (r_f3_valid) begin
                r_f4_valid <= 1'b1;
            end else if (w_load) begin
                r_f4_valid <= 1'b0;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_p_hi <= $signed(i_acc[47:24]) * i_slope;
            r_p_lo <= $signed({1'b0, i_acc[23:0]}) * i_slope;
        end
        if (r_f1_valid) begin
            r_f2_sat <= w_sat_hi || w_sat_lo;
            if (w_sat_hi) begin
                r_f2_clamp <= 16'h7FFF;
            end else if (w_sat_lo) begin
                r_f2_clamp <= 16'h8000;
            end else begin
                r_f2_clamp <= w_z[15:0];
            end
        end
        if (r_f2_valid) begin
            r_f3_idx   <= w_tprod[16 +: TW];
            r_f3_clamp <= r_f2_clamp;
            r_f3_sat   <= r_f2_sat;
        end
        if (r_f3_valid) begin
            r_f4_u     <= w_table[r_f3_idx];
            r_f4_clamp <= r_f3_clamp;
            r_f4_sat   <= r_f3_sat;
        end
        if (w_load) begin
            r_out_res <= n_out_res;
        end
    end

    assign o_done      = w_load;
    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out_res;

endmodule

`default_nettype wire

>>> hdl/neuron_weighted_sum_sigmoid.sv
// Top level of the single neuron: weight memory, multiply-accumulate and transfer stage.
`default_nettype none

// A single neuron. A request with op clear writes its value into the weight memory
// at its index (indexes at or above MAX_INPUTS are dropped); a request with op set
// is a sample, which is multiplied by the weight at the running position and added
// to a 48-bit sum that starts from the bias at the first sample of each vector.
// Samples beyond MAX_INPUTS add nothing. The sample marked last produces one result:
// the sum is scaled by the slope, rounded to Q4.12, and passed through the unary
// sigmoid, the binary sigmoid or a saturating linear stage, chosen by mode.
// Weight writes and ordinary samples are taken one per cycle unless a pending result
// holds them off; the multiply-accumulate runs as a three-stage pipeline behind the
// weight memory's registered read port, and a weight write takes effect for the very
// next sample. A sample marked last holds off further requests until its result has
// moved into the output register, which happens only when the output side is free.
// On its way the result passes the weight read, the product and the accumulate,
// followed by the slope multiply, clamp, table index and registered table read.
// While a result waits in the output register, new requests are still taken.
// Weights come out of reset undefined and must be written before they are used.
// The configuration port is always ready and must only be written while the block
// is idle.

module neuron_weighted_sum_sigmoid #(
    parameter int MAX_INPUTS          = nwss_pkg::MAX_INPUTS_DEF,
    parameter int SIGMOID_TABLE_DEPTH = nwss_pkg::SIG_DEPTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [nwss_pkg::CFG_W-1:0]    i_cfg_index,
    input  wire logic [nwss_pkg::VALUE_W-1:0]  i_cfg_data,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire nwss_pkg::t_in                 i_in_req,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output nwss_pkg::t_out                     o_out_res
);

    localparam int AW = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
    localparam int PW = $clog2(MAX_INPUTS + 1);

    // Configuration registers.
    logic [nwss_pkg::MODE_W-1:0]         r_mode;
    logic signed [nwss_pkg::VALUE_W-1:0] r_slope;
    logic signed [nwss_pkg::VALUE_W-1:0] r_bias;

    // Front end: position counter and the hold-off flag for a pending result.
    logic [PW-1:0] r_pos;
    logic [PW-1:0] n_pos;
    logic          r_busy;

    // Stage one: weight read in flight.
    logic                                r_s1_valid;
    logic                                r_s1_first;
    logic                                r_s1_add;
    logic                                r_s1_last;
    logic signed [nwss_pkg::VALUE_W-1:0] r_s1_value;

    // Stage two: product ready to accumulate.
    logic                               r_s2_valid;
    logic                               r_s2_first;
    logic                               r_s2_last;
    logic signed [nwss_pkg::PROD_W-1:0] r_s2_prod;

    // Accumulator and the start strobe for the transfer stage.
    logic [nwss_pkg::ACC_W-1:0] r_acc;
    logic [nwss_pkg::ACC_W-1:0] n_acc;
    logic                       r_fin;

    logic                         w_accept;
    logic                         w_sample;
    logic                         w_wr_en;
    logic [nwss_pkg::VALUE_W-1:0] w_rdata;
    logic [nwss_pkg::ACC_W-1:0]   w_bias_q24;
    logic                         w_done;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_busy;

    assign w_accept = i_in_valid && o_in_ready;
    assign w_sample = w_accept && (i_in_req.op == nwss_pkg::OP_SAMPLE);
    assign w_wr_en  = w_accept && (i_in_req.op == nwss_pkg::OP_WEIGHT) &&
                      ({{(32 - nwss_pkg::INDEX_W){1'b0}}, i_in_req.index} < 32'(MAX_INPUTS));

    // Weight memory, read at the running position every cycle.
    nwss_ram #(
        .WIDTH (nwss_pkg::VALUE_W),
        .DEPTH (MAX_INPUTS)
    ) u_weights (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (AW'(i_in_req.index)),
        .i_wr_data (i_in_req.value),
        .i_rd_addr (r_pos[AW-1:0]),
        .o_rd_data (w_rdata)
    );

    // The position stops at MAX_INPUTS and returns to zero after the last sample.
    always_comb begin
        n_pos = r_pos;
        if (w_sample) begin
            if (i_in_req.last) begin
                n_pos = '0;
            end else if (r_pos < PW'(MAX_INPUTS)) begin
                n_pos = r_pos + PW'(1);
            end
        end
    end

    // The bias enters the sum in Q.24, so it is shifted up by twelve bits.
    assign w_bias_q24 = {{(nwss_pkg::ACC_W - nwss_pkg::VALUE_W - 12){r_bias[15]}},
                         r_bias, 12'b0};
    assign n_acc = (r_s2_first ? w_bias_q24 : r_acc) +
                   {{(nwss_pkg::ACC_W - nwss_pkg::PROD_W){r_s2_prod[31]}}, r_s2_prod};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= nwss_pkg::MODE_UNARY;
            r_slope    <= nwss_pkg::SLOPE_RST;
            r_bias     <= '0;
            r_pos      <= '0;
            r_busy     <= 1'b0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_fin      <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    nwss_pkg::CFG_MODE:  r_mode  <= i_cfg_data[nwss_pkg::MODE_W-1:0];
                    nwss_pkg::CFG_SLOPE: r_slope <= i_cfg_data;
                    nwss_pkg::CFG_BIAS:  r_bias  <= i_cfg_data;
                    default: ;
                endcase
            end
            r_pos <= n_pos;
            if (w_sample && i_in_req.last) begin
                r_busy <= 1'b1;
            end else if (w_done) begin
                r_busy <= 1'b0;
            end
            r_s1_valid <= w_sample;
            r_s2_valid <= r_s1_valid;
            r_fin      <= r_s2_valid && r_s2_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_sample) begin
            r_s1_first <= (r_pos == '0);
            r_s1_add   <= (r_pos < PW'(MAX_INPUTS));
            r_s1_last  <= i_in_req.last;
            r_s1_value <= i_in_req.value;
        end
        if (r_s1_valid) begin
            r_s2_first <= r_s1_first;
            r_s2_last  <= r_s1_last;
            // Both factors are signed, so the product is formed on its own.
            if (r_s1_add) begin
                r_s2_prod <= r_s1_value * $signed(w_rdata);
            end else begin
                r_s2_prod <= '0;
            end
        end
        if (r_s2_valid) begin
            r_acc <= n_acc;
        end
    end

    // Slope scaling, transfer function and the output register.
    nwss_act #(
        .SIGMOID_TABLE_DEPTH (SIGMOID_TABLE_DEPTH)
    ) u_act (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (r_fin),
        .i_acc       (r_acc),
        .i_mode      (r_mode),
        .i_slope     (r_slope),
        .o_done      (w_done),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_res   (o_out_res)
    );

endmodule

`default_nettype wire
